### hw/rtl/next_lexicographic_permutation_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the next lexicographic permutation block
// Same-cycle and next-cycle implication checks, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef NEXT_LEXICOGRAPHIC_PERMUTATION_ASSERT_SVH
`define NEXT_LEXICOGRAPHIC_PERMUTATION_ASSERT_SVH

// ante holds in a cycle -> cons holds in the same cycle
`define NLP_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("nlp: same-cycle check failed");

// ante holds in a cycle -> cons holds in the next cycle
`define NLP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("nlp: next-cycle check failed");

`endif

### hw/rtl/nlp_pkg.sv
// ----------------------------------------------------------------------------
// nlp_pkg
// Shared constants, datapath operation codes and the command/status structs
// that join the permutation controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nlp_pkg;

    localparam int WORD_BITS     = 64;
    localparam int LEN_BITS      = 5;
    localparam int LENGTH_RESET  = 16;
    localparam int MAX_LEN_DEF   = 16;
    localparam int ELEM_BITS_DEF = 4;

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_START_LOAD,
        OP_LOAD_STEP,
        OP_START_ADV,
        OP_PIV_STEP,
        OP_PIV_TAKE,
        OP_SUCC_STEP,
        OP_SUCC_TAKE,
        OP_SWAP,
        OP_REV_ISSUE,
        OP_REV_W1,
        OP_REV_W2,
        OP_SWEEP
    } nlp_op_t;

    typedef struct packed {
        nlp_op_t op;
        logic    out_load;
        logic    adv;
    } nlp_cmd_t;

    typedef struct packed {
        logic len_lt2;
        logic piv_hit;
        logic piv_last;
        logic succ_hit;
        logic rev_more;
        logic rev_more2;
        logic k_last;
        logic k_done;
    } nlp_stat_t;

endpackage

### hw/rtl/nlp_dp.sv
// ----------------------------------------------------------------------------
// nlp_dp
// Datapath: element memory with one write and two registered read ports,
// scan pointers, pivot and swap holding registers, and the packed word
// shift register that mirrors the memory contents.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nlp_dp #(
    parameter int MAX_LEN   = nlp_pkg::MAX_LEN_DEF,
    parameter int ELEM_BITS = nlp_pkg::ELEM_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [nlp_pkg::LEN_BITS-1:0]   cfg_length,
    input  logic [nlp_pkg::WORD_BITS-1:0]  load_word,
    input  nlp_pkg::nlp_cmd_t              cmd,
    output nlp_pkg::nlp_stat_t             stat,
    output logic [nlp_pkg::WORD_BITS-1:0]  perm_word,
    output logic                           advanced
);

    localparam int IW    = $clog2(MAX_LEN);
    localparam int CW    = $clog2(MAX_LEN + 1);
    localparam int W     = MAX_LEN * ELEM_BITS;
    localparam int DEPTH = 1 << IW;

    logic [ELEM_BITS-1:0] mem [DEPTH];

    logic [nlp_pkg::LEN_BITS-1:0]  length_reg;
    logic                          loaded_reg;
    logic [W-1:0]                  shreg_reg;
    logic [ELEM_BITS-1:0]          rdata_a_reg;
    logic [ELEM_BITS-1:0]          rdata_b_reg;
    logic [ELEM_BITS-1:0]          piv_reg;
    logic [ELEM_BITS-1:0]          tmp_reg;
    logic [IW-1:0]                 chk_reg;
    logic [IW-1:0]                 p_reg;
    logic [IW-1:0]                 q_reg;
    logic [IW-1:0]                 lo_reg;
    logic [IW-1:0]                 hi_reg;
    logic [CW-1:0]                 k_reg;
    logic [nlp_pkg::WORD_BITS-1:0] perm_word_reg;
    logic                          advanced_reg;

    logic [CW-1:0]        n;
    logic [IW-1:0]        n_m1;
    logic [IW-1:0]        n_m2;
    logic                 we;
    logic [IW-1:0]        waddr;
    logic [ELEM_BITS-1:0] wdata;
    logic [IW-1:0]        raddr_a;
    logic [IW-1:0]        raddr_b;

    // elements in use, saturated at MAX_LEN
    always_comb begin
        if (length_reg > nlp_pkg::LEN_BITS'(MAX_LEN)) begin
            n = CW'(MAX_LEN);
        end else begin
            n = length_reg[CW-1:0];
        end
        n_m1 = IW'(n - CW'(1));
        n_m2 = IW'(n - CW'(2));
    end

    // memory port steering
    always_comb begin
        we      = 1'b0;
        waddr   = p_reg;
        wdata   = rdata_a_reg;
        raddr_a = k_reg[IW-1:0];
        raddr_b = hi_reg;
        unique case (cmd.op)
            nlp_pkg::OP_START_ADV: begin
                raddr_a = n_m2;
                raddr_b = n_m1;
            end
            nlp_pkg::OP_PIV_STEP: begin
                raddr_a = chk_reg - IW'(2);
                raddr_b = chk_reg - IW'(1);
            end
            nlp_pkg::OP_PIV_TAKE: begin
                raddr_a = n_m1;
            end
            nlp_pkg::OP_SUCC_STEP: begin
                raddr_a = q_reg - IW'(1);
            end
            nlp_pkg::OP_SUCC_TAKE: begin
                we    = 1'b1;
                waddr = p_reg;
                wdata = rdata_a_reg;
            end
            nlp_pkg::OP_SWAP: begin
                we    = 1'b1;
                waddr = q_reg;
                wdata = piv_reg;
            end
            nlp_pkg::OP_REV_ISSUE: begin
                raddr_a = lo_reg;
                raddr_b = hi_reg;
            end
            nlp_pkg::OP_REV_W1: begin
                we    = 1'b1;
                waddr = lo_reg;
                wdata = rdata_b_reg;
            end
            nlp_pkg::OP_REV_W2: begin
                we      = 1'b1;
                waddr   = hi_reg;
                wdata   = tmp_reg;
                raddr_a = lo_reg + IW'(1);
                raddr_b = hi_reg - IW'(1);
            end
            nlp_pkg::OP_LOAD_STEP: begin
                we    = 1'b1;
                waddr = k_reg[IW-1:0];
                wdata = shreg_reg[ELEM_BITS-1:0];
            end
            nlp_pkg::OP_SWEEP: begin
                raddr_a = k_reg[IW-1:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // before the first load every entry reads as zero
    always_ff @(posedge aclk) begin
        rdata_a_reg <= loaded_reg ? mem[raddr_a] : '0;
        rdata_b_reg <= loaded_reg ? mem[raddr_b] : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            length_reg <= nlp_pkg::LEN_BITS'(nlp_pkg::LENGTH_RESET);
            loaded_reg <= 1'b0;
            shreg_reg  <= '0;
        end else begin
            if (cfg_we) begin
                length_reg <= cfg_length;
            end
            unique case (cmd.op)
                nlp_pkg::OP_START_LOAD: begin
                    loaded_reg <= 1'b1;
                    shreg_reg  <= load_word[W-1:0];
                end
                // rotate, so the word is intact once every element is written
                nlp_pkg::OP_LOAD_STEP: begin
                    shreg_reg <= {shreg_reg[ELEM_BITS-1:0], shreg_reg[W-1:ELEM_BITS]};
                end
                nlp_pkg::OP_SWEEP: begin
                    if (k_reg != '0) begin
                        shreg_reg <= {rdata_a_reg, shreg_reg[W-1:ELEM_BITS]};
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            nlp_pkg::OP_START_LOAD: begin
                k_reg <= '0;
            end
            nlp_pkg::OP_LOAD_STEP: begin
                k_reg <= k_reg + CW'(1);
            end
            nlp_pkg::OP_START_ADV: begin
                chk_reg <= n_m1;
            end
            nlp_pkg::OP_PIV_STEP: begin
                chk_reg <= chk_reg - IW'(1);
            end
            nlp_pkg::OP_PIV_TAKE: begin
                p_reg   <= chk_reg - IW'(1);
                piv_reg <= rdata_a_reg;
                q_reg   <= n_m1;
            end
            nlp_pkg::OP_SUCC_STEP: begin
                q_reg <= q_reg - IW'(1);
            end
            nlp_pkg::OP_SWAP: begin
                lo_reg <= p_reg + IW'(1);
                hi_reg <= n_m1;
                k_reg  <= '0;
            end
            nlp_pkg::OP_REV_W1: begin
                tmp_reg <= rdata_a_reg;
            end
            nlp_pkg::OP_REV_W2: begin
                lo_reg <= lo_reg + IW'(1);
                hi_reg <= hi_reg - IW'(1);
            end
            nlp_pkg::OP_SWEEP: begin
                k_reg <= k_reg + CW'(1);
            end
            default: ;
        endcase
        if (cmd.out_load) begin
            perm_word_reg <= nlp_pkg::WORD_BITS'(shreg_reg);
            advanced_reg  <= cmd.adv;
        end
    end

    always_comb begin
        stat.len_lt2   = n < CW'(2);
        stat.piv_hit   = rdata_a_reg < rdata_b_reg;
        stat.piv_last  = chk_reg == IW'(1);
        // the element just right of the pivot is always larger
        stat.succ_hit  = (rdata_a_reg > piv_reg) || (q_reg == p_reg + IW'(1));
        stat.rev_more  = lo_reg < hi_reg;
        stat.rev_more2 = ({1'b0, lo_reg} + (IW + 1)'(2)) < {1'b0, hi_reg};
        stat.k_last    = k_reg == CW'(MAX_LEN - 1);
        stat.k_done    = k_reg == CW'(MAX_LEN);
    end

    assign perm_word = perm_word_reg;
    assign advanced  = advanced_reg;

endmodule

### hw/rtl/nlp_ctrl.sv
// ----------------------------------------------------------------------------
// nlp_ctrl
// Sequencer for load and advance: pivot scan, successor scan, swap, suffix
// reversal, readout sweep and result handoff.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nlp_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_cmd,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  nlp_pkg::nlp_stat_t  stat,
    output nlp_pkg::nlp_cmd_t   cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_LOAD   = 4'd1;
    localparam logic [3:0] S_PIV    = 4'd2;
    localparam logic [3:0] S_SUCC   = 4'd3;
    localparam logic [3:0] S_SWAP   = 4'd4;
    localparam logic [3:0] S_REV_RD = 4'd5;
    localparam logic [3:0] S_REV_W1 = 4'd6;
    localparam logic [3:0] S_REV_W2 = 4'd7;
    localparam logic [3:0] S_RDOUT  = 4'd8;
    localparam logic [3:0] S_FINISH = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       adv_reg;
    logic       m_valid_reg;
    logic       accept;

    assign s_ready = state_reg == S_IDLE;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        cmd.op       = nlp_pkg::OP_NONE;
        cmd.out_load = 1'b0;
        cmd.adv      = adv_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (s_cmd == nlp_pkg::CMD_LOAD) begin
                        cmd.op     = nlp_pkg::OP_START_LOAD;
                        state_next = S_LOAD;
                    end else if (stat.len_lt2) begin
                        state_next = S_FINISH;
                    end else begin
                        cmd.op     = nlp_pkg::OP_START_ADV;
                        state_next = S_PIV;
                    end
                end
            end
            S_LOAD: begin
                cmd.op = nlp_pkg::OP_LOAD_STEP;
                if (stat.k_last) begin
                    state_next = S_FINISH;
                end
            end
            S_PIV: begin
                if (stat.piv_hit) begin
                    cmd.op     = nlp_pkg::OP_PIV_TAKE;
                    state_next = S_SUCC;
                end else if (stat.piv_last) begin
                    // last arrangement: leave the store as is
                    state_next = S_FINISH;
                end else begin
                    cmd.op = nlp_pkg::OP_PIV_STEP;
                end
            end
            S_SUCC: begin
                if (stat.succ_hit) begin
                    cmd.op     = nlp_pkg::OP_SUCC_TAKE;
                    state_next = S_SWAP;
                end else begin
                    cmd.op = nlp_pkg::OP_SUCC_STEP;
                end
            end
            S_SWAP: begin
                cmd.op     = nlp_pkg::OP_SWAP;
                state_next = S_REV_RD;
            end
            S_REV_RD: begin
                if (stat.rev_more) begin
                    cmd.op     = nlp_pkg::OP_REV_ISSUE;
                    state_next = S_REV_W1;
                end else begin
                    state_next = S_RDOUT;
                end
            end
            S_REV_W1: begin
                cmd.op     = nlp_pkg::OP_REV_W1;
                state_next = S_REV_W2;
            end
            S_REV_W2: begin
                cmd.op = nlp_pkg::OP_REV_W2;
                if (stat.rev_more2) begin
                    state_next = S_REV_W1;
                end else begin
                    state_next = S_RDOUT;
                end
            end
            S_RDOUT: begin
                cmd.op = nlp_pkg::OP_SWEEP;
                if (stat.k_done) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                // hold until the output register is free or being drained
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            adv_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                adv_reg <= 1'b0;
            end else if (cmd.op == nlp_pkg::OP_PIV_TAKE) begin
                adv_reg <= 1'b1;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

### hw/rtl/next_lexicographic_permutation.sv
// A load word is written into the store one element per cycle through the
// single write port. In an advance the pivot and successor scans compare one
// element pair per cycle, the suffix reversal needs two memory writes per
// pair, and a readout sweep repacks the word; at the last arrangement it
// finishes right after the pivot scan, and with fewer than two elements it
// finishes at once. One item is in work at a time; a finished result waits
// in the output register and the next word is taken while it waits.
// ----------------------------------------------------------------------------
// next_lexicographic_permutation
// Steps a stored sequence of small elements to its next lexicographic
// (multiset) arrangement, or reloads it from a packed word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "next_lexicographic_permutation_assert.svh"

module next_lexicographic_permutation #(
    parameter int MAX_LEN   = nlp_pkg::MAX_LEN_DEF,
    parameter int ELEM_BITS = nlp_pkg::ELEM_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [nlp_pkg::LEN_BITS-1:0]   cfg_length,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_cmd,
    input  logic [nlp_pkg::WORD_BITS-1:0]  s_load_word,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [nlp_pkg::WORD_BITS-1:0]  m_perm_word,
    output logic                           m_advanced
);

    nlp_pkg::nlp_cmd_t  ctl_cmd;
    nlp_pkg::nlp_stat_t dp_stat;

    assign cfg_ready = 1'b1;

    nlp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_cmd   (s_cmd),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (dp_stat),
        .cmd     (ctl_cmd)
    );

    nlp_dp #(
        .MAX_LEN   (MAX_LEN),
        .ELEM_BITS (ELEM_BITS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_length (cfg_length),
        .load_word  (s_load_word),
        .cmd        (ctl_cmd),
        .stat       (dp_stat),
        .perm_word  (m_perm_word),
        .advanced   (m_advanced)
    );

    `NLP_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    `NLP_ASSERT_SAME(a_no_result_overwrite, aclk, aresetn, ctl_cmd.out_load, !m_valid || m_ready)
    `NLP_ASSERT_NEXT(a_result_shown, aclk, aresetn, ctl_cmd.out_load, m_valid)

endmodule
